// ----- src/bksq_pkg.sv -----
// ----------------------------------------------------------------------------
// bksq_pkg: shared types, tables and round functions
// gf(2^8) arithmetic, aes s-box, byte permutation and key schedule step
// ----------------------------------------------------------------------------
`default_nettype none

package bksq_pkg;

  localparam int BksqRounds = 10;
  localparam int BksqBytes  = 12;
  localparam int HalfW      = 48;

  // byte 0 sits in the top bits, matching the packed tdata halves
  typedef logic [0:BksqBytes-1][7:0] bksq_bytes_t;

  typedef struct packed {
    bksq_bytes_t st;
    bksq_bytes_t rk;
  } bksq_blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  // destination byte i takes source byte PERM_SRC[i]
  localparam logic [3:0] PERM_SRC [BksqBytes] = '{
    4'd0, 4'd10, 4'd8, 4'd3, 4'd1, 4'd11, 4'd6, 4'd4, 4'd2, 4'd9, 4'd7, 4'd5
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = x[7] ? ((x << 1) ^ 8'h1B) : (x << 1);
  endfunction

  // one operand is always a constant, so this folds into an xor network
  function automatic logic [7:0] gf_mul(input logic [7:0] c, input logic [7:0] x);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = x;
    for (int n = 0; n < 8; n++) begin
      if (c[n]) acc = acc ^ sh;
      sh = xtime(sh);
    end
    gf_mul = acc;
  endfunction

  // round constant after n doublings of one
  function automatic logic [7:0] rcon(input int n);
    logic [7:0] rc;
    rc = 8'h01;
    for (int k = 0; k < n; k++) rc = xtime(rc);
    rcon = rc;
  endfunction

  function automatic bksq_bytes_t mix_cols(input bksq_bytes_t s, input logic [7:0] dg,
                                           input logic [7:0] of);
    bksq_bytes_t r;
    for (int c = 0; c < BksqBytes; c += 3) begin
      r[c]   = gf_mul(dg, s[c])   ^ gf_mul(of, s[c+1]) ^ gf_mul(of, s[c+2]);
      r[c+1] = gf_mul(of, s[c])   ^ gf_mul(dg, s[c+1]) ^ gf_mul(of, s[c+2]);
      r[c+2] = gf_mul(of, s[c])   ^ gf_mul(of, s[c+1]) ^ gf_mul(dg, s[c+2]);
    end
    mix_cols = r;
  endfunction

  function automatic bksq_bytes_t sub_perm(input bksq_bytes_t s);
    bksq_bytes_t r;
    for (int i = 0; i < BksqBytes; i++) r[i] = SBOX[s[PERM_SRC[i]]];
    sub_perm = r;
  endfunction

  function automatic bksq_bytes_t next_key(input bksq_bytes_t k, input logic [7:0] rc);
    bksq_bytes_t r;
    r[0] = SBOX[k[10]] ^ k[0] ^ rc;
    r[1] = SBOX[k[11]] ^ k[1];
    r[2] = SBOX[k[9]]  ^ k[2];
    for (int i = 3; i < BksqBytes; i++) r[i] = r[i-3] ^ k[i];
    next_key = r;
  endfunction

endpackage

`default_nettype wire

// ----- src/bksq_style_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// bksq_style_block_encrypt: 96-bit block encryption, one round per cell
// fully unrolled chain of round cells taking, unless the output stalls, one request per cycle
// ----------------------------------------------------------------------------
// usage
//   slave side: a request carries plaintext and key (four 48-bit halves) and
//   is taken when s_axis_tvalid and s_axis_tready are both high
//   master side: one ciphertext per request, in request order, handed over
//   when m_axis_tvalid and m_axis_tready are both high
// path: an accepted request reaches m_axis_tvalid through one cell
//   per round plus the initial whitening cell, each ending in a register
// throughput: one request per cycle unless the output stalls; the round chain is fully
//   unrolled and every gf multiply is by a constant, so each round is combinational logic
// stall: each cell loads while it is empty or its content moves on, so
//   bubbles close up and requests keep entering while a result waits; a
//   full chain with m_axis_tready low holds everything and drops s_axis_tready
// reset: rst_ni clears all cell valid flags; no request is in flight after it
// ----------------------------------------------------------------------------
`default_nettype none

module bksq_style_block_encrypt #(
  parameter int ROUNDS = bksq_pkg::BksqRounds
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // plain_upper [47:0], plain_lower [95:48], key_upper [143:96], key_lower [191:144]
  input  wire  [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // cipher_upper [47:0], cipher_lower [95:48]
  output logic [95:0]  m_axis_tdata
);
  import bksq_pkg::*;

  localparam int NCells = ROUNDS + 1;

  // link k feeds cell k; link NCells is the chain output
  logic      vld [NCells+1];
  logic      rdy [NCells+1];
  bksq_blk_t blk [NCells+1];

  // unpack the request into byte-ordered state and key
  assign vld[0]    = s_axis_tvalid;
  assign s_axis_tready = rdy[0];
  assign blk[0].st = {s_axis_tdata[HalfW-1:0],     s_axis_tdata[2*HalfW-1:HalfW]};
  assign blk[0].rk = {s_axis_tdata[3*HalfW-1:2*HalfW], s_axis_tdata[4*HalfW-1:3*HalfW]};

  for (genvar k = 0; k < NCells; k++) begin : g_cell
    // cell k applies the key update with the constant after k+1 doublings
    bksq_cell #(
      .IsInit (k == 0),
      .Rc     (rcon(k + 1))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .blk_i   (blk[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .blk_o   (blk[k+1])
    );
  end

  // last cell register doubles as the output register
  assign rdy[NCells]   = m_axis_tready;
  assign m_axis_tvalid = vld[NCells];
  assign m_axis_tdata  = {blk[NCells].st[6:11], blk[NCells].st[0:5]};

  // an empty last cell means the whole chain can take a request
  a_empty_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("chain blocked with empty output cell");

  // a receiver that is ready never backs up the chain
  a_sink_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is drained");

  // an accepted request lands in the first cell
  a_first_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld[1])
    else $error("accepted request lost at first cell");

endmodule

`default_nettype wire

// ----- src/bksq_cell.sv -----
// ----------------------------------------------------------------------------
// bksq_cell: one round stage of the cipher chain
// holds a state and round key; unless stalled by ready_i, computes one round and the next key per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bksq_cell #(
  parameter bit         IsInit = 1'b0,
  parameter logic [7:0] Rc     = 8'h02
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       valid_i,
  output logic                      ready_o,
  input  wire bksq_pkg::bksq_blk_t  blk_i,
  output logic                      valid_o,
  input  wire                       ready_i,
  output bksq_pkg::bksq_blk_t       blk_o
);
  import bksq_pkg::*;

  logic      valid_q;
  bksq_blk_t blk_d, blk_q;

  // stage may load when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (IsInit) begin
      blk_d.st = mix_cols(blk_i.st, 8'd246, 8'd247) ^ blk_i.rk;
    end else begin
      blk_d.st = sub_perm(mix_cols(blk_i.st, 8'd3, 8'd2)) ^ blk_i.rk;
    end
    blk_d.rk = next_key(blk_i.rk, Rc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

`default_nettype wire
